### src/modbus_rtu_register_slave_unit_defines.svh
// assertion macros for the modbus register slave
`ifndef MODBUS_RTU_REGISTER_SLAVE_UNIT_DEFINES_SVH
`define MODBUS_RTU_REGISTER_SLAVE_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define MRS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("mrs assertion failed");

// consequence holds in the cycle after the trigger
`define MRS_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("mrs assertion failed");

`endif

### src/mrs_pkg.sv
// shared types and constants of the modbus register slave
package mrs_pkg;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_CHK_RD   = 11'b000_0000_0010,
		S_CHK_BYTE = 11'b000_0000_0100,
		S_CHK_NEXT = 11'b000_0000_1000,
		S_CRC      = 11'b000_0001_0000,
		S_DEC      = 11'b000_0010_0000,
		S_WR_RD    = 11'b000_0100_0000,
		S_WR_BYTE  = 11'b000_1000_0000,
		S_EMIT     = 11'b001_0000_0000,
		S_TXLO     = 11'b010_0000_0000,
		S_TXHI     = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		K_EXC  = 2'd0,
		K_READ = 2'd1,
		K_ECHO = 2'd2,
		K_WM   = 2'd3
	} kind_t;

	localparam logic [1:0]  CFG_NODE_ADDR = 2'd0;
	localparam logic [1:0]  CFG_GAP       = 2'd1;
	localparam logic [1:0]  CFG_RO_MASK   = 2'd2;

	localparam logic [7:0]  FC_READ_HOLD   = 8'h03;
	localparam logic [7:0]  FC_WRITE_ONE   = 8'h06;
	localparam logic [7:0]  FC_WRITE_MULTI = 8'h10;
	localparam logic [7:0]  EXC_FLAG       = 8'h80;

	localparam logic [1:0]  EXC_FUNC  = 2'd1;
	localparam logic [1:0]  EXC_ADDR  = 2'd2;
	localparam logic [1:0]  EXC_VALUE = 2'd3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam int MIN_FRAME   = 5;
	localparam int MIN_REQ     = 8;
	localparam int MIN_WM_REQ  = 9;
	localparam int MAX_QTY     = 64;
	localparam int WM_DATA_OFS = 7;

endpackage

### src/modbus_rtu_register_slave_unit.sv
// modbus rtu slave with holding registers: top level
// a received byte or a non-closing tick is taken only in the idle state
// a closing tick reads each frame byte into one bit-serial crc unit, skipping the crc bytes
// then stores multiple-write data and emits each response byte once the output is free
// the next request is taken once the last response byte sits in the output register
// asynchronous reset clears the frame state and register store, sets config defaults
`include "modbus_rtu_register_slave_unit_defines.svh"
module modbus_rtu_register_slave_unit #(
	parameter int REG_COUNT = 16,
	parameter int RX_DEPTH  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        last
);

	localparam int AW  = $clog2(RX_DEPTH);
	localparam int LW  = $clog2(RX_DEPTH + 1);
	localparam int RW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int CW  = $clog2(REG_COUNT + 1);
	localparam int RLW = $clog2(3 + 2 * REG_COUNT + 1);

	mrs_pkg::state_t state_q, ret_q;
	mrs_pkg::kind_t  kind_q;

	logic [7:0]  node_q, gap_q;
	logic [15:0] ro_mask_q;

	logic [7:0]  mem [RX_DEPTH];
	logic [7:0]  rd_q;
	logic [15:0] store_q [REG_COUNT];

	logic [LW-1:0]  flen_q, plen_q, idx_q;
	logic           receiving_q;
	logic [7:0]     idle_q;
	logic [15:0]    crc_q;
	logic [2:0]     bit_q;
	logic [7:0]     hdr_q [7];
	logic [7:0]     rxlo_q, rxhi_q, hi_q;
	logic [1:0]     code_q;
	logic [RLW-1:0] rlen_q, k_q;
	logic [RW-1:0]  rptr_q, wptr_q;
	logic [CW-1:0]  cnt_q;
	logic           half_q;
	logic           out_valid_q, last_q;
	logic [7:0]     tx_q;

	logic        acc, out_free, close;
	logic [7:0]  idle_inc;
	logic [7:0]  fc;
	logic [15:0] reg_w, qty_w;
	logic [16:0] reg_end;
	logic        addr_ok, crc_ok, range_bad, qty_bad, bc_bad, data_short, ro_hit;
	logic        short8, short9, ws_reg_bad;
	logic [5:0]  q_win;
	logic [31:0] win;
	logic [7:0]  gen_byte;
	logic [7:0]  crc_x;
	logic        store_we;
	logic [RW-1:0] store_wa;
	logic [15:0] store_wd;

	assign in_stall  = (state_q != mrs_pkg::S_IDLE);
	assign acc       = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign tx_byte   = tx_q;
	assign last      = last_q;

	assign idle_inc = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
	assign close    = acc && cmd && receiving_q && (idle_inc >= gap_q);

	// request decode
	assign fc         = hdr_q[1];
	assign reg_w      = {hdr_q[2], hdr_q[3]};
	assign qty_w      = {hdr_q[4], hdr_q[5]};
	assign reg_end    = {1'b0, reg_w} + {1'b0, qty_w};
	assign addr_ok    = (hdr_q[0] == node_q) || (hdr_q[0] == 8'd0);
	assign crc_ok     = ({rxhi_q, rxlo_q} == crc_q);
	assign range_bad  = reg_end > 17'(REG_COUNT);
	assign qty_bad    = (qty_w == 16'd0) || (qty_w > 16'(mrs_pkg::MAX_QTY));
	assign bc_bad     = {9'd0, hdr_q[6]} != {qty_w, 1'b0};
	assign data_short = (10'(hdr_q[6]) + 10'(mrs_pkg::MIN_WM_REQ)) > 10'(plen_q);
	assign short8     = plen_q < LW'(mrs_pkg::MIN_REQ);
	assign short9     = plen_q < LW'(mrs_pkg::MIN_WM_REQ);
	assign ws_reg_bad = reg_w >= 16'(REG_COUNT);
	assign q_win      = (fc == mrs_pkg::FC_WRITE_ONE) ? 6'd1 : qty_w[5:0];
	assign win        = ((32'd1 << q_win) - 32'd1) << reg_w[4:0];
	assign ro_hit     = |(win & {16'd0, ro_mask_q});

	// response byte generator
	always_comb begin
		if (k_q == RLW'(0)) begin
			gen_byte = (kind_q == mrs_pkg::K_ECHO) ? hdr_q[0] : node_q;
		end else if (k_q == RLW'(1)) begin
			gen_byte = (kind_q == mrs_pkg::K_EXC) ? (hdr_q[1] | mrs_pkg::EXC_FLAG) : hdr_q[1];
		end else if (k_q == RLW'(2)) begin
			case (kind_q)
				mrs_pkg::K_EXC:  gen_byte = 8'(code_q);
				mrs_pkg::K_READ: gen_byte = {qty_w[6:0], 1'b0};
				default:         gen_byte = hdr_q[2];
			endcase
		end else if (kind_q == mrs_pkg::K_READ) begin
			gen_byte = k_q[0] ? store_q[rptr_q][15:8] : store_q[rptr_q][7:0];
		end else begin
			gen_byte = hdr_q[k_q[2:0]];
		end
	end

	assign crc_x = (state_q == mrs_pkg::S_EMIT) ? gen_byte : rd_q;

	// register store write port
	always_comb begin
		store_we = 1'b0;
		store_wa = reg_w[RW-1:0];
		store_wd = qty_w;
		if (state_q == mrs_pkg::S_DEC && addr_ok && crc_ok && fc == mrs_pkg::FC_WRITE_ONE
				&& !short8 && !ws_reg_bad && !ro_hit) begin
			store_we = 1'b1;
		end else if (state_q == mrs_pkg::S_WR_BYTE && half_q) begin
			store_we = 1'b1;
			store_wa = wptr_q;
			store_wd = {hi_q, rd_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				store_q[i] <= 16'd0;
			end
		end else if (store_we) begin
			store_q[store_wa] <= store_wd;
		end
	end

	// frame buffer
	always_ff @(posedge clk) begin
		if (acc && !cmd && flen_q < LW'(RX_DEPTH)) begin
			mem[flen_q[AW-1:0]] <= rx_byte;
		end
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q    <= 8'd1;
			gap_q     <= 8'd2;
			ro_mask_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrs_pkg::CFG_NODE_ADDR: node_q    <= cfg_data[7:0];
				mrs_pkg::CFG_GAP:       gap_q     <= cfg_data[7:0];
				mrs_pkg::CFG_RO_MASK:   ro_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrs_pkg::S_IDLE;
			ret_q       <= mrs_pkg::S_IDLE;
			kind_q      <= mrs_pkg::K_EXC;
			flen_q      <= '0;
			plen_q      <= '0;
			idx_q       <= '0;
			receiving_q <= 1'b0;
			idle_q      <= 8'd0;
			crc_q       <= mrs_pkg::CRC_INIT;
			bit_q       <= 3'd0;
			for (int i = 0; i < 7; i++) begin
				hdr_q[i] <= 8'd0;
			end
			rxlo_q      <= 8'd0;
			rxhi_q      <= 8'd0;
			hi_q        <= 8'd0;
			code_q      <= mrs_pkg::EXC_FUNC;
			rlen_q      <= '0;
			k_q         <= '0;
			rptr_q      <= '0;
			wptr_q      <= '0;
			cnt_q       <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			tx_q        <= 8'd0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				mrs_pkg::S_IDLE: begin
					if (acc && !cmd) begin
						if (flen_q < LW'(RX_DEPTH)) begin
							flen_q <= flen_q + LW'(1);
						end
						receiving_q <= 1'b1;
						idle_q      <= 8'd0;
					end else if (acc && receiving_q) begin
						idle_q <= idle_inc;
						if (close) begin
							plen_q      <= flen_q;
							flen_q      <= '0;
							receiving_q <= 1'b0;
							idle_q      <= 8'd0;
							idx_q       <= '0;
							crc_q       <= mrs_pkg::CRC_INIT;
							if (flen_q >= LW'(mrs_pkg::MIN_FRAME)) begin
								state_q <= mrs_pkg::S_CHK_RD;
							end
						end
					end
				end
				mrs_pkg::S_CHK_RD: begin
					state_q <= mrs_pkg::S_CHK_BYTE;
				end
				mrs_pkg::S_CHK_BYTE: begin
					if (idx_q < LW'(7)) begin
						hdr_q[idx_q[2:0]] <= rd_q;
					end
					if (idx_q == plen_q - LW'(2)) begin
						rxlo_q <= rd_q;
					end
					if (idx_q == plen_q - LW'(1)) begin
						rxhi_q <= rd_q;
					end
					if (idx_q < plen_q - LW'(2)) begin
						crc_q   <= crc_q ^ {8'd0, crc_x};
						bit_q   <= 3'd0;
						ret_q   <= mrs_pkg::S_CHK_NEXT;
						state_q <= mrs_pkg::S_CRC;
					end else begin
						state_q <= mrs_pkg::S_CHK_NEXT;
					end
				end
				mrs_pkg::S_CHK_NEXT: begin
					if (idx_q == plen_q - LW'(1)) begin
						state_q <= mrs_pkg::S_DEC;
					end else begin
						idx_q   <= idx_q + LW'(1);
						state_q <= mrs_pkg::S_CHK_RD;
					end
				end
				mrs_pkg::S_CRC: begin
					crc_q <= crc_q[0] ? ((crc_q >> 1) ^ mrs_pkg::CRC_POLY) : (crc_q >> 1);
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						state_q <= ret_q;
					end
				end
				mrs_pkg::S_DEC: begin
					k_q    <= '0;
					rptr_q <= reg_w[RW-1:0];
					rlen_q <= RLW'(3);
					kind_q <= mrs_pkg::K_EXC;
					state_q <= mrs_pkg::S_EMIT;
					if (!addr_ok || !crc_ok) begin
						state_q <= mrs_pkg::S_IDLE;
					end else begin
						unique case (fc)
							mrs_pkg::FC_READ_HOLD: begin
								if (short8) begin
									code_q <= mrs_pkg::EXC_FUNC;
								end else if (qty_bad) begin
									code_q <= mrs_pkg::EXC_VALUE;
								end else if (range_bad) begin
									code_q <= mrs_pkg::EXC_ADDR;
								end else begin
									kind_q <= mrs_pkg::K_READ;
									rlen_q <= RLW'(3) + {qty_w[RLW-2:0], 1'b0};
								end
							end
							mrs_pkg::FC_WRITE_ONE: begin
								if (short8) begin
									code_q <= mrs_pkg::EXC_FUNC;
								end else if (ws_reg_bad || ro_hit) begin
									code_q <= mrs_pkg::EXC_ADDR;
								end else begin
									kind_q <= mrs_pkg::K_ECHO;
									rlen_q <= RLW'(6);
								end
							end
							mrs_pkg::FC_WRITE_MULTI: begin
								if (short9) begin
									code_q <= mrs_pkg::EXC_FUNC;
								end else if (qty_bad || bc_bad || data_short) begin
									code_q <= mrs_pkg::EXC_VALUE;
								end else if (range_bad || ro_hit) begin
									code_q <= mrs_pkg::EXC_ADDR;
								end else begin
									kind_q  <= mrs_pkg::K_WM;
									rlen_q  <= RLW'(6);
									idx_q   <= LW'(mrs_pkg::WM_DATA_OFS);
									wptr_q  <= reg_w[RW-1:0];
									cnt_q   <= qty_w[CW-1:0];
									half_q  <= 1'b0;
									state_q <= mrs_pkg::S_WR_RD;
								end
							end
							default: begin
								code_q <= mrs_pkg::EXC_FUNC;
							end
						endcase
					end
					crc_q <= mrs_pkg::CRC_INIT;
				end
				mrs_pkg::S_WR_RD: begin
					state_q <= mrs_pkg::S_WR_BYTE;
				end
				mrs_pkg::S_WR_BYTE: begin
					idx_q   <= idx_q + LW'(1);
					half_q  <= !half_q;
					state_q <= mrs_pkg::S_WR_RD;
					if (!half_q) begin
						hi_q <= rd_q;
					end else begin
						wptr_q <= wptr_q + RW'(1);
						cnt_q  <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							state_q <= mrs_pkg::S_EMIT;
						end
					end
				end
				mrs_pkg::S_EMIT: begin
					if (k_q == rlen_q) begin
						state_q <= mrs_pkg::S_TXLO;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						tx_q        <= gen_byte;
						last_q      <= 1'b0;
						crc_q       <= crc_q ^ {8'd0, crc_x};
						bit_q       <= 3'd0;
						k_q         <= k_q + RLW'(1);
						if (kind_q == mrs_pkg::K_READ && k_q >= RLW'(4) && !k_q[0]) begin
							rptr_q <= rptr_q + RW'(1);
						end
						ret_q   <= mrs_pkg::S_EMIT;
						state_q <= mrs_pkg::S_CRC;
					end
				end
				mrs_pkg::S_TXLO: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						tx_q        <= crc_q[7:0];
						last_q      <= 1'b0;
						state_q     <= mrs_pkg::S_TXHI;
					end
				end
				mrs_pkg::S_TXHI: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						tx_q        <= crc_q[15:8];
						last_q      <= 1'b1;
						state_q     <= mrs_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= mrs_pkg::S_IDLE;
				end
			endcase
		end
	end

	`MRS_ASSERT_ALWAYS(a_flen_bound, flen_q <= LW'(RX_DEPTH))
	`MRS_ASSERT_NEXT(a_byte_opens, acc && !cmd, receiving_q && idle_q == 8'd0)
	`MRS_ASSERT_NEXT(a_close_clears, close, !receiving_q && flen_q == '0)

endmodule
